// ----- src/ksd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types, keyword table and case folding for the keyword substring
// detector.
// ----------------------------------------------------------------------------
package ksd_pkg;

    localparam int WindowDepth  = 8;
    localparam int KeywordCount = 30;
    localparam int KeywordMax   = 9;
    localparam int KwBits       = KeywordMax * 8;
    localparam int LenBits      = $clog2(KeywordMax + 1);

    typedef logic [7:0] byte_t;
    typedef byte_t [WindowDepth-1:0] window_t;

    // Keywords, right-justified: bits [8d+7:8d] hold the letter that lies
    // d positions before the end of the word. Upper bytes are padding.
    localparam logic [KwBits-1:0] KeywordText [KeywordCount] = '{
        72'h6675636b,
        72'h6469636b,
        72'h7075737379,
        72'h73686974,
        72'h6b756b,
        72'h6669747461,
        72'h68656c76657465,
        72'h6b7574,
        72'h6c756c,
        72'h72656574,
        72'h6d65726465,
        72'h70757461696e,
        72'h626f7264656c,
        72'h6368696572,
        72'h62697465,
        72'h636f75696c6c65,
        72'h63756c,
        72'h70757465,
        72'h636f6e,
        72'h7065726b656c65,
        72'h7363686569737365,
        72'h6d697374,
        72'h6b61636b65,
        72'h61727363686c6f6368,
        72'h746f6e746f,
        72'h70757461,
        72'h736174616e,
        72'h66616e64656e,
        72'h68656c76656465,
        72'h6d6963726f736f6674
    };

    localparam logic [LenBits-1:0] KeywordLen [KeywordCount] = '{
        4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd7, 4'd3, 4'd3, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd7, 4'd3, 4'd4, 4'd3, 4'd7,
        4'd8, 4'd4, 4'd5, 4'd9, 4'd5, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9
    };

    localparam byte_t AsciiUpperA = 8'h41;
    localparam byte_t AsciiUpperZ = 8'h5a;
    localparam byte_t AsciiCaseBit = 8'h20;

    // Fold ASCII A-Z to lower case, leave every other byte as it is.
    function automatic byte_t fold_case(input byte_t raw);
        byte_t c;
        c = raw;
        if (raw >= AsciiUpperA && raw <= AsciiUpperZ) begin
            c = raw | AsciiCaseBit;
        end
        return c;
    endfunction

endpackage

// ----- src/keyword_substring_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_substring_detector
// Streams a string one byte per item, folds case, and reports on the last
// byte whether any keyword of the fixed list occurred as a substring.
// ----------------------------------------------------------------------------
// Result: registered; it appears in the output register in the cycle after the
//   last byte of a string is accepted.
// Throughput: one byte per cycle unless a result waits on a stalled output;
//   the keyword compare is combinational, so bytes and strings run back to back.
// Reset: synchronous, active low; clears the window, the hit flag and the
//   output valid.
module keyword_substring_detector (
    input  logic       aclk,
    input  logic       aresetn,
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_text
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] keyword_found, [7:1] zero
);

    logic              s_accept;
    ksd_pkg::byte_t    cur_byte;
    ksd_pkg::window_t  window;
    logic              hit_now;

    logic              hit_seen_reg;
    logic              hit_seen_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic              found_reg;
    logic              found_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cur_byte = ksd_pkg::fold_case(s_tdata);

    // Window: a chain of byte cells, cell 0 takes the current byte
    genvar i;
    generate
        for (i = 0; i < ksd_pkg::WindowDepth; i++) begin : g_cell
            ksd_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .advance (s_accept),
                .clear   (s_tlast),
                .din     ((i == 0) ? cur_byte : window[(i == 0) ? 0 : i-1]),
                .dout    (window[i])
            );
        end
    endgenerate

    ksd_match u_match (
        .cur_byte (cur_byte),
        .window   (window),
        .hit      (hit_now)
    );

    // Update the sticky flag and load the result on the last byte
    always_comb begin
        hit_seen_next = hit_seen_reg;
        m_tvalid_next = m_tvalid_reg;
        found_next    = found_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept) begin
            if (s_tlast) begin
                hit_seen_next = 1'b0;
                m_tvalid_next = 1'b1;
                found_next    = hit_seen_reg || hit_now;
            end else begin
                hit_seen_next = hit_seen_reg || hit_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_seen_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            hit_seen_reg <= hit_seen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, found_reg};

    // Last byte accepted: a result is offered in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> m_tvalid_reg)
        else $error("no result after last byte");

    // Last byte accepted: window head and hit flag are cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> (window[0] == '0) && !hit_seen_reg)
        else $error("state not cleared at end of string");

    // The hit flag drops only at the end of a string
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(hit_seen_reg) && $past(aresetn) |-> $past(s_accept && s_tlast))
        else $error("hit flag lost inside a string");

    // Input stalls only behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && !m_tready)
        else $error("input stalled without a pending result");

endmodule

// ----- src/ksd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_cell
// One byte cell of the history window: takes its neighbor's byte on each
// accepted item and drops to zero at the end of a string.
// ----------------------------------------------------------------------------
module ksd_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            clear,
    input  ksd_pkg::byte_t  din,
    output ksd_pkg::byte_t  dout
);

    ksd_pkg::byte_t byte_reg;
    ksd_pkg::byte_t byte_next;

    // Shift in the neighbor's byte, or clear at the end of a string
    always_comb begin
        byte_next = byte_reg;
        if (advance) begin
            byte_next = clear ? '0 : din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

// ----- src/ksd_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_match
// Parallel keyword compare: checks whether any keyword ends at the current
// byte, using the current byte and the window of earlier bytes.
// ----------------------------------------------------------------------------
module ksd_match (
    input  ksd_pkg::byte_t    cur_byte,
    input  ksd_pkg::window_t  window,
    output logic              hit
);

    ksd_pkg::byte_t [ksd_pkg::KeywordMax-1:0] taps;
    logic [ksd_pkg::KeywordCount-1:0]         word_hit;

    // Tap d is the byte d positions back from the current one
    always_comb begin
        taps[0] = cur_byte;
        for (int d = 1; d < ksd_pkg::KeywordMax; d++) begin
            taps[d] = window[d-1];
        end
    end

    // Compare every keyword against the taps it spans
    always_comb begin
        for (int w = 0; w < ksd_pkg::KeywordCount; w++) begin
            word_hit[w] = 1'b1;
            for (int d = 0; d < ksd_pkg::KeywordMax; d++) begin
                if (d < int'(ksd_pkg::KeywordLen[w]) &&
                    taps[d] != ksd_pkg::KeywordText[w][8*d +: 8]) begin
                    word_hit[w] = 1'b0;
                end
            end
        end
    end

    assign hit = |word_hit;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword substring detector. Strings are fed
// one byte per item, with keywords planted in random case between filler
// letters, near misses and raw bytes. A local scanner predicts the verdict
// of every string, and each result item is compared with the oldest
// prediction. Random gaps on the input side and random stalls on the result
// side cover back-pressure; the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QuietLimit = 1000;
    localparam int WordCount  = 30;
    localparam int WordMax    = 9;

    // Keywords, right-justified: the lowest byte is the final letter
    localparam logic [8*WordMax-1:0] Words [WordCount] = '{
        "fuck", "dick", "pussy", "shit", "kuk", "fitta", "helvete", "kut",
        "lul", "reet", "merde", "putain", "bordel", "chier", "bite",
        "couille", "cul", "pute", "con", "perkele", "scheisse", "mist",
        "kacke", "arschloch", "tonto", "puta", "satan", "fanden", "helvede",
        {"micro", "soft"}
    };

    // Indexes of keywords used by the directed tests
    localparam int WordKuk       = 4;
    localparam int WordCon       = 18;
    localparam int WordArschloch = 23;

    // Case modes for planted keywords
    typedef enum int {CaseMixed, CaseUpper, CaseLower} case_mode_t;

    localparam logic [7:0] UpperA   = 8'h41;
    localparam logic [7:0] UpperZ   = 8'h5a;
    localparam logic [7:0] LowerA   = 8'h61;
    localparam logic [7:0] LowerZ   = 8'h7a;
    localparam logic [7:0] CaseDiff = 8'h20;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic       s_tlast  = 1'b0;    // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] keyword_found, [7:1] zero

    // Scanner state and pending verdicts
    logic [7:0] scan_window [8];
    logic       scan_hit;
    logic       verdict_q [$];
    logic [7:0] line_buf [$];

    int  errors       = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    bit  calm         = 1'b0;
    logic [7:0] verdict_word;

    keyword_substring_detector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Count letters of a right-justified keyword
    function automatic int word_len(input logic [8*WordMax-1:0] w);
        int n;
        n = 0;
        while (n < WordMax && w[8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    // Advance the scanner by one accepted byte; queue a verdict on the last
    function automatic void scan_byte(input logic [7:0] raw, input logic last);
        logic [7:0] cur;
        logic [7:0] b;
        logic       ok;
        int         len;
        cur = raw;
        if (raw >= UpperA && raw <= UpperZ) cur = raw + CaseDiff;
        for (int i = 0; i < WordCount; i++) begin
            len = word_len(Words[i]);
            ok = 1'b1;
            for (int d = 0; d < len; d++) begin
                b = (d == 0) ? cur : scan_window[d-1];
                if (b != Words[i][8*d +: 8]) ok = 1'b0;
            end
            if (ok) scan_hit = 1'b1;
        end
        for (int i = 7; i > 0; i--) scan_window[i] = scan_window[i-1];
        scan_window[0] = cur;
        if (last) begin
            verdict_q.push_back(scan_hit);
            scan_hit = 1'b0;
            for (int i = 0; i < 8; i++) scan_window[i] = 8'h00;
        end
    endfunction

    function automatic logic [7:0] set_case(input logic [7:0] c, input case_mode_t mode);
        logic up;
        up = (mode == CaseUpper) || (mode == CaseMixed && $urandom_range(0, 1) == 1);
        if (up && c >= LowerA && c <= LowerZ) return c - CaseDiff;
        return c;
    endfunction

    function automatic logic [7:0] random_letter();
        return set_case(8'($urandom_range(LowerA, LowerZ)), CaseMixed);
    endfunction

    // Append a keyword to the line, leaving off its last drop letters
    function automatic void push_word(input int idx, input int drop, input case_mode_t mode);
        int len;
        len = word_len(Words[idx]);
        for (int d = len - 1; d >= drop; d--)
            line_buf.push_back(set_case(Words[idx][8*d +: 8], mode));
    endfunction

    // Send one byte; entered and left at a falling edge
    task automatic send_item(input logic [7:0] text_byte, input logic end_of_text);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        s_tlast  <= end_of_text;
        do @(posedge aclk); while (!s_tready);
        scan_byte(text_byte, end_of_text);
        @(negedge aclk);
    endtask

    // Send the buffered line as one string and empty the buffer
    task automatic send_line();
        foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // Hold the input until every pending verdict has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (verdict_q.size() != 0);
    endtask

    // One-byte strings at both ends of the byte range
    task automatic test_byte_extremes();
        line_buf.push_back(8'h00);
        send_line();
        line_buf.push_back(8'hff);
        send_line();
    endtask

    // Shortest keyword alone, all upper case
    task automatic test_short_upper();
        push_word(WordKuk, 0, CaseUpper);
        send_line();
    endtask

    // Nine-letter keyword filling the window plus the current byte
    task automatic test_full_window();
        push_word(WordArschloch, 0, CaseMixed);
        send_line();
    endtask

    // Keyword split across two strings must not hit
    task automatic test_string_boundary();
        push_word(WordCon, 1, CaseLower);
        send_line();
        line_buf.push_back(Words[WordCon][7:0]);
        send_line();
    endtask

    // Bytes next to the fold range, a zero byte mid-string, a high-bit letter
    task automatic test_odd_bytes();
        line_buf = '{8'h40, 8'h5b, 8'h00, 8'hcb, 8'h75, 8'h6b};
        send_line();
    endtask

    // Random strings: mostly planted keywords, some near misses, some noise
    task automatic test_random_strings(input int budget);
        int kind;
        while (budget > 0) begin
            kind = $urandom_range(0, 9);
            repeat ($urandom_range(0, 6)) line_buf.push_back(random_letter());
            if (kind < 6) begin
                push_word($urandom_range(0, WordCount - 1), 0, CaseMixed);
            end else if (kind < 8) begin
                push_word($urandom_range(0, WordCount - 1), 1, CaseMixed);
            end else begin
                repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 4)) line_buf.push_back(random_letter());
            budget -= line_buf.size();
            send_line();
        end
    endtask

    // Result-side stalls in bursts of random length
    always @(negedge aclk) begin
        if (!aresetn || calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result item against the oldest pending verdict
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                verdict_word = {7'b0, verdict_q.pop_front()};
                if (m_tdata[0] !== verdict_word[0] || m_tdata[7:1] !== verdict_word[7:1]) begin
                    $display("%0t: keyword_found expected %h, actual %h",
                             $time, verdict_word, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Abort when no item moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
            $display("keyword_substring_detector: mismatch");
            $finish;
        end
    end

    initial begin
        scan_hit = 1'b0;
        for (int i = 0; i < 8; i++) scan_window[i] = 8'h00;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_byte_extremes();
        test_short_upper();
        test_full_window();
        test_string_boundary();
        test_odd_bytes();
        hold_until_drained();
        test_random_strings(600);
        calm = 1'b1;
        test_random_strings(150);

        // Drain remaining verdicts, then let the output register settle
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("keyword_substring_detector: match");
        end else begin
            $display("keyword_substring_detector: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/ksd_pkg.sv
src/ksd_cell.sv
src/ksd_match.sv
src/keyword_substring_detector.sv
bench/tb_top.sv
